>>> rtl/ltc_pkg.sv
// shared types and constants for the lru tile cache
// no dependencies
package ltc_pkg;

	localparam int STORE_DEPTH_DEF   = 256;
	localparam int PENDING_DEPTH_DEF = 8;
	localparam int MAX_ZOOM_DEF      = 19;
	localparam int KEY_W             = 43;
	localparam int MAX_RESULTS       = 8;
	localparam logic [7:0] TILE_LIMIT_RST  = 8'd220;
	localparam logic [3:0] FETCH_LIMIT_RST = 4'd6;

	localparam logic [2:0] ACT_REQUEST  = 3'd0;
	localparam logic [2:0] ACT_PROBE    = 3'd1;
	localparam logic [2:0] ACT_ADVANCE  = 3'd2;
	localparam logic [2:0] ACT_COMPLETE = 3'd3;
	localparam logic [2:0] ACT_SWEEP    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [0:0] REG_TILE_LIMIT  = 1'b0;
	localparam logic [0:0] REG_FETCH_LIMIT = 1'b1;

	typedef struct packed {
		logic [31:0] tile_handle;
		logic        fetch_issued;
		logic        freed_valid;
		logic [31:0] freed_handle;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [4:0]  zoom;
		logic [18:0] tile_x;
		logic [18:0] tile_y;
		logic [31:0] new_handle;
	} request_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SWEEP_INIT, S_SWEEP_SCAN,
		S_SWEEP_WAIT, S_SWEEP_EVICT, S_EMIT
	} state_t;

endpackage

>>> rtl/ltc_if.sv
// valid/ready channel carrying a request or a result payload
// no dependencies; the payload type is a parameter
interface ltc_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ltc_store.sv
// tile store memory: key, handle, stamp in one synchronous ram, valid bits in flops
// depends on ltc_pkg
module ltc_store import ltc_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [AW-1:0]     rd_addr,
	output logic [KEY_W-1:0]  rd_key,
	output logic [31:0]       rd_handle,
	output logic [31:0]       rd_stamp,
	output logic              rd_valid,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [KEY_W-1:0]  wr_key,
	input  logic [31:0]       wr_handle,
	input  logic [31:0]       wr_stamp,
	input  logic              set_valid,
	input  logic              clr_valid,
	input  logic [AW-1:0]     v_addr
);
	logic [KEY_W+63:0] mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [KEY_W+63:0] rd_q;
	logic rdv_q;

	// memory port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_key, wr_handle, wr_stamp};
		rd_q <= mem[rd_addr];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (set_valid) valid_q[v_addr] <= 1'b1;
			if (clr_valid) valid_q[v_addr] <= 1'b0;
			rdv_q <= valid_q[rd_addr];
		end
	end

	assign rd_key    = rd_q[KEY_W+63:64];
	assign rd_handle = rd_q[63:32];
	assign rd_stamp  = rd_q[31:0];
	assign rd_valid  = rdv_q;
endmodule

>>> rtl/lru_tile_cache_with_fetch_limit.sv
// lru tile cache top level: control sequencer, pending table, output register
// depends on ltc_pkg, ltc_if, ltc_store
//
// Fully associative tile cache keyed by zoom:x:y. Every lookup or completion
// scans the store memory one entry per cycle; a sweep rescans the store once
// per evicted entry, up to 8 passes. Frame advance and out of range requests
// skip the scan. The scan rate is set by the single read port of the store
// memory. Results leave through a one-entry output register; the next request
// is taken once the last result is queued.
module lru_tile_cache_with_fetch_limit import ltc_pkg::*; #(
	parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
	parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
	parameter int MAX_ZOOM      = MAX_ZOOM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ltc_if.sink        req,
	ltc_if.source      rsp,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int SCW = $clog2(STORE_DEPTH + 1);

	state_t state_q, state_d;
	request_t item_q;
	logic [KEY_W-1:0] key;
	logic [7:0] tile_limit_q;
	logic [3:0] fetch_limit_q;
	logic [31:0] frame_q;
	logic [AW:0] cnt_q;
	logic [AW-1:0] rd_addr;
	logic [KEY_W-1:0] rd_key;
	logic [31:0] rd_handle, rd_stamp;
	logic rd_valid;
	logic hit_q, free_q;
	logic [AW-1:0] hit_idx_q, free_idx_q;
	logic [31:0] hit_handle_q;
	logic [KEY_W-1:0] best_key_q;
	logic [31:0] best_stamp_q, best_handle_q;
	logic [AW-1:0] best_idx_q;
	logic best_ok_q;
	logic [SCW-1:0] vcount_q;
	logic [3:0] evicted_q;
	logic last_scan_q;
	logic [KEY_W-1:0] pend_key_q [PENDING_DEPTH];
	logic [PENDING_DEPTH-1:0] pend_v_q;
	result_t res_q;
	logic res_v_q;
	logic wr_en, set_v, clr_v;
	logic [AW-1:0] v_addr;
	logic [31:0] wr_handle;
	result_t emit_r;
	logic emit;

	assign key = {item_q.zoom, item_q.tile_x, item_q.tile_y};
	assign rd_addr = cnt_q[AW-1:0];

	ltc_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
		.clk, .arst_n, .rd_addr, .rd_key, .rd_handle, .rd_stamp, .rd_valid,
		.wr_en, .wr_addr(v_addr), .wr_key(key), .wr_handle, .wr_stamp(frame_q),
		.set_valid(set_v), .clr_valid(clr_v), .v_addr
	);

	// pending table search
	logic pmatch, pfree_any;
	logic [PW-1:0] pmatch_idx, pfree_idx;
	logic [CW-1:0] pcount;
	logic [3:0] cap;
	always_comb begin
		pmatch = 1'b0; pmatch_idx = '0; pfree_any = 1'b0; pfree_idx = '0; pcount = '0;
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (pend_v_q[i] && pend_key_q[i] == key) begin
				pmatch = 1'b1; pmatch_idx = PW'(i);
			end
			if (!pend_v_q[i]) begin
				pfree_any = 1'b1; pfree_idx = PW'(i);
			end
			pcount = pcount + CW'(pend_v_q[i]);
		end
		cap = (32'(fetch_limit_q) < PENDING_DEPTH) ? fetch_limit_q : 4'(PENDING_DEPTH);
	end

	// range check
	logic in_range;
	always_comb begin
		in_range = (32'(item_q.zoom) <= MAX_ZOOM)
			&& ((20'(item_q.tile_x) >> item_q.zoom) == 20'd0)
			&& ((20'(item_q.tile_y) >> item_q.zoom) == 20'd0);
	end

	// candidate comparison for the sweep
	logic better;
	assign better = !best_ok_q || rd_stamp < best_stamp_q
		|| (rd_stamp == best_stamp_q && rd_key < best_key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_DECIDE;
			S_SCAN: state_d = S_SCAN_WAIT;
			S_SCAN_WAIT: if (last_scan_q) state_d = S_EMIT;
			S_DECIDE: begin
				unique case (item_q.action)
					ACT_REQUEST, ACT_PROBE, ACT_COMPLETE: state_d =
						(item_q.action == ACT_REQUEST && !in_range) ? S_EMIT : S_SCAN;
					ACT_SWEEP: state_d = S_SWEEP_INIT;
					default: state_d = S_EMIT;
				endcase
			end
			S_SWEEP_INIT: state_d = S_SWEEP_SCAN;
			S_SWEEP_SCAN: state_d = S_SWEEP_WAIT;
			S_SWEEP_WAIT: if (last_scan_q) state_d = S_SWEEP_EVICT;
			S_SWEEP_EVICT: begin
				if (res_v_q) state_d = S_SWEEP_EVICT;
				else if (best_ok_q && 32'(vcount_q) > 32'(tile_limit_q)
					&& evicted_q < 4'(MAX_RESULTS - 1)
					&& 32'(vcount_q) - 1 > 32'(tile_limit_q)) state_d = S_SWEEP_INIT;
				else state_d = S_IDLE;
			end
			S_EMIT: if (!res_v_q) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// result formation and store writes
	always_comb begin
		emit = 1'b0; emit_r = '0; emit_r.last = 1'b1;
		wr_en = 1'b0; set_v = 1'b0; clr_v = 1'b0; v_addr = hit_idx_q; wr_handle = hit_handle_q;
		if (state_q == S_EMIT && !res_v_q) begin
			emit = 1'b1;
			unique case (item_q.action)
				ACT_REQUEST, ACT_PROBE: begin
					if (item_q.action == ACT_REQUEST && !in_range) emit_r.status = ST_RANGE;
					else if (hit_q) begin
						emit_r.tile_handle = hit_handle_q;
						wr_en = 1'b1;
					end else if (item_q.action == ACT_REQUEST && !pmatch
						&& 32'(pcount) < 32'(cap) && pfree_any)
						emit_r.fetch_issued = 1'b1;
				end
				ACT_COMPLETE: begin
					if (pmatch) begin
						wr_handle = item_q.new_handle;
						if (hit_q) begin
							wr_en = 1'b1;
							emit_r.tile_handle = item_q.new_handle;
							emit_r.freed_valid = hit_handle_q != 32'd0;
							emit_r.freed_handle = hit_handle_q;
						end else if (free_q) begin
							wr_en = 1'b1; set_v = 1'b1; v_addr = free_idx_q;
							emit_r.tile_handle = item_q.new_handle;
						end else begin
							emit_r.status = ST_FULL;
							emit_r.freed_valid = item_q.new_handle != 32'd0;
							emit_r.freed_handle = item_q.new_handle;
						end
					end
				end
				default: ;
			endcase
		end else if (state_q == S_SWEEP_EVICT && !res_v_q) begin
			emit = 1'b1;
			v_addr = best_idx_q;
			if (best_ok_q && 32'(vcount_q) > 32'(tile_limit_q)) begin
				clr_v = 1'b1;
				emit_r.freed_valid = best_handle_q != 32'd0;
				emit_r.freed_handle = best_handle_q;
				emit_r.last = state_d == S_IDLE;
			end
		end
	end

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tile_limit_q <= TILE_LIMIT_RST;
			fetch_limit_q <= FETCH_LIMIT_RST;
			frame_q <= '0;
			pend_v_q <= '0;
			res_v_q <= 1'b0;
			cnt_q <= '0;
			last_scan_q <= 1'b0;
			evicted_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_TILE_LIMIT) tile_limit_q <= cfg_data;
				else fetch_limit_q <= cfg_data[3:0];
			end
			if (rsp.valid && rsp.ready) res_v_q <= 1'b0;
			if (emit) res_v_q <= 1'b1;
			if (state_q == S_DECIDE) evicted_q <= '0;
			if (state_q == S_SWEEP_EVICT && clr_v) evicted_q <= evicted_q + 4'd1;
			if (state_q == S_DECIDE && item_q.action == ACT_ADVANCE) frame_q <= frame_q + 32'd1;
			if (state_q == S_SCAN || state_q == S_SWEEP_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
				last_scan_q <= 1'b0;
			end else if (state_q == S_SCAN_WAIT || state_q == S_SWEEP_WAIT) begin
				last_scan_q <= cnt_q == (AW+1)'(STORE_DEPTH);
				if (cnt_q != (AW+1)'(STORE_DEPTH)) cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
				last_scan_q <= 1'b0;
			end
			// pending table updates
			if (emit && state_q == S_EMIT) begin
				if (emit_r.fetch_issued) pend_v_q[pfree_idx] <= 1'b1;
				if (item_q.action == ACT_COMPLETE && pmatch) pend_v_q[pmatch_idx] <= 1'b0;
			end
		end
	end

	// payload registers: request capture, scan results, pending keys, result
	logic scan_live;
	logic [AW-1:0] scan_idx;
	assign scan_live = (state_q == S_SCAN_WAIT || state_q == S_SWEEP_WAIT) && !last_scan_q;
	assign scan_idx = AW'(cnt_q - 1'b1);
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) item_q <= req.data;
		if (state_q == S_DECIDE || state_q == S_SWEEP_INIT) begin
			hit_q <= 1'b0; free_q <= 1'b0; best_ok_q <= 1'b0; vcount_q <= '0;
		end
		if (scan_live && state_q == S_SCAN_WAIT) begin
			if (rd_valid && rd_key == key && !hit_q) begin
				hit_q <= 1'b1; hit_idx_q <= scan_idx; hit_handle_q <= rd_handle;
			end
			if (!rd_valid && !free_q) begin
				free_q <= 1'b1; free_idx_q <= scan_idx;
			end
		end
		if (scan_live && state_q == S_SWEEP_WAIT && rd_valid) begin
			vcount_q <= vcount_q + 1'b1;
			if (better) begin
				best_ok_q <= 1'b1; best_idx_q <= scan_idx; best_key_q <= rd_key;
				best_stamp_q <= rd_stamp; best_handle_q <= rd_handle;
			end
		end
		if (emit && state_q == S_EMIT && emit_r.fetch_issued) pend_key_q[pfree_idx] <= key;
		if (emit) res_q <= emit_r;
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = res_v_q;
	assign rsp.data = res_q;
endmodule
